@@ rtl/qmrr_pkg.sv @@
package qmrr_pkg;

  localparam int unsigned CW      = 32;          // coefficient and root width
  localparam int unsigned FB      = 16;          // fractional bits
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned DISC_W  = 2 * CW + 2;  // b^2 + 4ac
  localparam int unsigned SQ_W    = CW + 1;      // integer square root
  localparam int unsigned SREM_W  = CW + 5;      // square root partial remainder
  localparam int unsigned NS_W    = CW + 4;      // signed numerator -b +/- s
  localparam int unsigned NM_W    = CW + 3;      // numerator magnitude
  localparam int unsigned NUM_W   = CW + FB + 4; // scaled dividend
  localparam int unsigned DEN_W   = CW + 1;      // divisor (2|a| or |b|)
  localparam int unsigned QH_W    = NUM_W - CW;  // dividend bits above the quotient window

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd6;

  // result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_DIV  = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] root;
    logic [1:0]           status;
  } res_t;

endpackage

@@ rtl/quadratic_max_real_root_unit.sv @@
// Largest real root of a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// The unit takes one coefficient triple in every clock cycle (busy_o stays
// low) and gives its result on res_o, marked by res_valid_o for one cycle,
// after passing through the sign split, the two 32x32 products and the
// discriminant, the square root stages (one root bit per stage), the
// numerator, the range check, the divider stages (one quotient bit per
// stage) and the output register. Results come out in order and cannot be
// held off by the receiver. zero_tolerance sits at byte address 0 of the APB
// port; the user must write it only while no item is in flight, and the unit
// leaves keeping to this to the user, without a check of its own.
module quadratic_max_real_root_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  qmrr_pkg::req_t     req_i,
  output logic               res_valid_o,
  output qmrr_pkg::res_t     res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qmrr_pkg::*;

  localparam int unsigned SQ_STAGES  = SQ_W;
  localparam int unsigned DIV_STAGES = CW;

  typedef struct packed {
    kind_e          kind;
    logic           lin;
    logic           an;
    logic           bn;
    logic           rneg;
    logic [CW-1:0]  am;
    logic [CW-1:0]  bm;
    logic [CW-1:0]  cm;
  } carry_t;

  typedef struct packed {
    carry_t              c;
    logic [DISC_W-1:0]   rad;
    logic [SREM_W-1:0]   rem;
    logic [SQ_W-1:0]     root;
  } sq_t;

  typedef struct packed {
    kind_e              kind;
    logic               rneg;
    logic               ovf;
    logic [NUM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [CW-1:0]      quo;
  } dv_t;

  // configuration register
  logic [TOL_W-1:0] tol_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-TOL_W){1'b0}}, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  assign busy_o = 1'b0;

  // stage 1: split signs and magnitudes, classify
  logic   s1_v_q;
  carry_t s1_q, s1_d;
  logic [CW-1:0] a_raw, b_raw, c_raw;

  always_comb begin
    a_raw = req_i.coef_a;
    b_raw = req_i.coef_b;
    c_raw = req_i.coef_c;
    s1_d.an = a_raw[CW-1];
    s1_d.bn = b_raw[CW-1];
    s1_d.am = a_raw[CW-1] ? (~a_raw + 1'b1) : a_raw;
    s1_d.bm = b_raw[CW-1] ? (~b_raw + 1'b1) : b_raw;
    s1_d.cm = c_raw[CW-1] ? (~c_raw + 1'b1) : c_raw;
    s1_d.lin = (s1_d.am == '0);
    s1_d.rneg = (c_raw[CW-1] == b_raw[CW-1]);
    if (s1_d.lin && s1_d.bm == '0) begin
      s1_d.kind = KIND_NONE;
    end else if (s1_d.lin && s1_d.cm <= {{(CW-TOL_W){1'b0}}, tol_q}) begin
      s1_d.kind = KIND_ZERO;
    end else begin
      s1_d.kind = KIND_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // stage 2: b^2 and a*c
  logic            s2_v_q;
  carry_t          s2_q;
  logic [2*CW-1:0] pbb_q, pac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q  <= s1_q;
    pbb_q <= s1_q.bm * s1_q.bm;
    pac_q <= s1_q.am * s1_q.cm;
  end

  // stage 3: discriminant, drop negative ones
  sq_t               sq_d [SQ_STAGES+1];
  logic              sq_v [SQ_STAGES+1];
  logic [DISC_W-1:0] p_ext, q4_ext, rad_d;
  carry_t            c3_d;

  // sign of c is recovered from rneg = (cn == bn)
  logic cn_s2;
  assign cn_s2 = ~(s2_q.rneg ^ s2_q.bn);

  always_comb begin
    p_ext = {2'b00, pbb_q};
    q4_ext = {pac_q, 2'b00};
    c3_d = s2_q;
    if (s2_q.an == cn_s2) begin
      rad_d = p_ext - q4_ext;
      if (!s2_q.lin && q4_ext > p_ext) begin
        c3_d.kind = KIND_NONE;
      end
    end else begin
      rad_d = p_ext + q4_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_d[0].c    <= c3_d;
    sq_d[0].rem  <= '0;
    sq_d[0].root <= '0;
    sq_d[0].rad  <= rad_d;
  end

  // square root stages: one root bit each
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    logic [SREM_W-1:0] rem2;
    logic [SREM_W-1:0] trial;

    always_comb begin
      rem2  = {sq_d[j].rem[SREM_W-3:0], sq_d[j].rad[DISC_W-1 -: 2]};
      trial = {{(SREM_W-SQ_W-2){1'b0}}, sq_d[j].root, 2'b01};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v[j+1] <= 1'b0;
      end else begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_d[j+1].c   <= sq_d[j].c;
      sq_d[j+1].rad <= {sq_d[j].rad[DISC_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        sq_d[j+1].rem  <= rem2 - trial;
        sq_d[j+1].root <= {sq_d[j].root[SQ_W-2:0], 1'b1};
      end else begin
        sq_d[j+1].rem  <= rem2;
        sq_d[j+1].root <= {sq_d[j].root[SQ_W-2:0], 1'b0};
      end
    end
  end

  // numerator stage: form dividend and divisor for either case
  carry_t            nc;
  logic signed [NS_W-1:0] mb_s, s_s, n_s;
  logic [NM_W-1:0]   nm;
  logic              nv_q;
  kind_e             nkind_q;
  logic              nrneg_q;
  logic [NUM_W-1:0]  nnum_q;
  logic [DEN_W-1:0]  nden_q;

  always_comb begin
    nc   = sq_d[SQ_STAGES].c;
    mb_s = nc.bn ? $signed({{(NS_W-CW){1'b0}}, nc.bm})
                 : -$signed({{(NS_W-CW){1'b0}}, nc.bm});
    s_s  = $signed({{(NS_W-SQ_W){1'b0}}, sq_d[SQ_STAGES].root});
    n_s  = nc.an ? (mb_s - s_s) : (mb_s + s_s);
    nm   = n_s[NS_W-1] ? NM_W'(-n_s) : NM_W'(n_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else begin
      nv_q <= sq_v[SQ_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    nkind_q <= nc.kind;
    if (nc.lin) begin
      nrneg_q <= nc.rneg;
      nnum_q  <= {{(NUM_W-CW-FB){1'b0}}, nc.cm, {FB{1'b0}}}
                 + {{(NUM_W-CW+1){1'b0}}, nc.bm[CW-1:1]};
      nden_q  <= {1'b0, nc.bm};
    end else begin
      nrneg_q <= n_s[NS_W-1] != nc.an;
      nnum_q  <= {{(NUM_W-NM_W-FB){1'b0}}, nm, {FB{1'b0}}}
                 + {{(NUM_W-CW){1'b0}}, nc.am};
      nden_q  <= {nc.am, 1'b0};
    end
  end

  // range check: quotient at or above 2^CW saturates
  dv_t  dv   [DIV_STAGES+1];
  logic dv_v [DIV_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= nv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv[0].kind <= nkind_q;
    dv[0].rneg <= nrneg_q;
    dv[0].ovf  <= {{(DEN_W-QH_W){1'b0}}, nnum_q[NUM_W-1:CW]} >= nden_q;
    dv[0].rem  <= nnum_q;
    dv[0].den  <= nden_q;
    dv[0].quo  <= '0;
  end

  // divider stages: one quotient bit each, most significant first
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int unsigned SH = DIV_STAGES - 1 - j;
    logic [NUM_W-1:0] top;
    logic [NUM_W-1:0] dsh;
    logic             take;

    always_comb begin
      top  = dv[j].rem >> SH;
      dsh  = {{(NUM_W-DEN_W){1'b0}}, dv[j].den} << SH;
      take = top >= {{(NUM_W-DEN_W){1'b0}}, dv[j].den};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      dv[j+1].kind <= dv[j].kind;
      dv[j+1].rneg <= dv[j].rneg;
      dv[j+1].ovf  <= dv[j].ovf;
      dv[j+1].den  <= dv[j].den;
      dv[j+1].rem  <= take ? (dv[j].rem - dsh) : dv[j].rem;
      dv[j+1].quo  <= {dv[j].quo[CW-2:0], take};
    end
  end

  // output register: saturate, apply sign, fill status
  dv_t           fin;
  logic [CW-1:0] lim, mag;
  logic          sat;
  res_t          res_d;

  always_comb begin
    fin   = dv[DIV_STAGES];
    lim   = fin.rneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    sat   = fin.ovf || (fin.quo > lim);
    mag   = sat ? lim : fin.quo;
    res_d = '0;
    case (fin.kind)
      KIND_NONE: begin
        res_d.status = ST_NONE;
      end
      KIND_ZERO: begin
        res_d.status = ST_OK;
      end
      KIND_DIV: begin
        res_d.root   = fin.rneg ? (~mag + 1'b1) : mag;
        res_d.status = sat ? ST_SAT : ST_OK;
      end
      default: begin
        res_d.status = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= dv_v[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

@@ sim/qmrr_checker.sv @@
`timescale 1ns / 100ps

// Watches the request, result and APB channels of the root unit, predicts
// every result and compares it with what the unit delivers.
module qmrr_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  qmrr_pkg::req_t     req_i,
  input  logic               res_valid_o,
  input  qmrr_pkg::res_t     res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatch_count,
  output int                 open_count
);
  import qmrr_pkg::*;

  localparam logic [2:0] ADDR_ZERO_TOL = 3'd0;

  logic [TOL_W-1:0] tol_shadow;
  res_t             pending_roots[$];

  // round(mag * 2^FB / d), ties away from zero
  function automatic logic [127:0] scaled_quot(logic [63:0] mag, logic [63:0] d);
    logic [127:0] num;
    num = ({64'd0, mag} << FB) + {65'd0, d[63:1]};
    return num / {64'd0, d};
  endfunction

  // saturate a magnitude to the root range and apply its sign
  function automatic res_t pack_root(logic neg, logic [127:0] m);
    logic [127:0] lim;
    res_t         r;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    r.status = ST_OK;
    if (m > lim) begin
      m = lim;
      r.status = ST_SAT;
    end
    r.root = neg ? -m[CW-1:0] : m[CW-1:0];
    return r;
  endfunction

  function automatic res_t max_real_root(req_t rq, logic [TOL_W-1:0] tol);
    logic         an, bn, cn, nneg;
    logic [31:0]  am, bm, cm;
    logic [127:0] sq_b, four_ac, disc, cand;
    logic [63:0]  s;
    logic signed [71:0] n;
    logic [63:0]  nm;
    res_t         r;
    an = rq.coef_a[CW-1];
    bn = rq.coef_b[CW-1];
    cn = rq.coef_c[CW-1];
    am = an ? -rq.coef_a : rq.coef_a;
    bm = bn ? -rq.coef_b : rq.coef_b;
    cm = cn ? -rq.coef_c : rq.coef_c;
    r.root = '0;
    r.status = ST_NONE;
    if (am == 0 && bm == 0) return r;
    // linear equation
    if (am == 0) begin
      r.status = ST_OK;
      if (cm <= tol) return r;
      return pack_root(cn == bn, scaled_quot({32'd0, cm}, {32'd0, bm}));
    end
    sq_b = {96'd0, bm} * {96'd0, bm};
    four_ac = ({96'd0, am} * {96'd0, cm}) << 2;
    if (cm != 0 && an == cn) begin
      if (four_ac > sq_b) return r;
      disc = sq_b - four_ac;
    end else begin
      disc = sq_b + four_ac;
    end
    // floor square root, one bit at a time
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = {64'd0, s | (64'd1 << i)};
      if (cand * cand <= disc) s = cand[63:0];
    end
    n = (bn ? $signed({40'd0, bm}) : -$signed({40'd0, bm}))
        + (an ? -$signed({8'd0, s}) : $signed({8'd0, s}));
    nneg = n < 0;
    nm = nneg ? 64'(-n) : 64'(n);
    return pack_root(nneg != an, scaled_quot(nm, {31'd0, am, 1'b0}));
  endfunction

  assign open_count = pending_roots.size();

  // track the register, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      tol_shadow <= TOL_RESET;
      mismatch_count <= 0;
      pending_roots.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_ZERO_TOL)
        tol_shadow <= pwdata[TOL_W-1:0];
      if (start_i && !busy_o)
        pending_roots.push_back(max_real_root(req_i, tol_shadow));
      if (res_valid_o) begin
        if (pending_roots.size() == 0) begin
          $error("result with no transfer waiting: root %0d status %0d",
                 res_o.root, res_o.status);
          errs++;
        end else begin
          exp_r = pending_roots.pop_front();
          if (res_o.root !== exp_r.root) begin
            $error("root: expected %0d, got %0d", exp_r.root, res_o.root);
            errs++;
          end
          if (res_o.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, res_o.status);
            errs++;
          end
        end
      end
      mismatch_count <= mismatch_count + errs;
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import qmrr_pkg::*;

  localparam int         PIPE_DEPTH = 80;
  localparam logic [2:0] ADDR_ZERO_TOL = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          open_count;
  int          sent_count = 0;

  always #5 clk_i = ~clk_i;

  quadratic_max_real_root_unit dut (.*);

  qmrr_checker u_checker (.*);

  // APB write: setup cycle, then access cycle
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one transfer; start stays high unless the sender idles afterwards
  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c, int idle_pct);
    req_i <= '{coef_a: a, coef_b: b, coef_c: c};
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent_count++;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // hold off until every result is in, let the pipe drain, then write the new tolerance
  task automatic drain_and_set(logic [15:0] tol);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
    apb_write(ADDR_ZERO_TOL, {16'd0, tol});
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return 32'($signed($urandom_range(0, 16)) - 8);
      3: return $urandom_range(1) ? S_MIN + $urandom_range(3) : S_MAX - $urandom_range(3);
      default: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
    endcase
  endfunction

  // mostly solvable equations built from two integer-ish roots, plus noise
  task automatic send_random(int count, int idle_pct);
    logic [31:0] a, b, c;
    int          r1, r2, k;
    repeat (count) begin
      k = $urandom_range(9);
      if (k < 5) begin
        a = 32'($signed($urandom_range(0, 8)) - 4);
        if (a == 0) a = 1;
        r1 = $signed($urandom_range(0, 200)) - 100;
        r2 = $signed($urandom_range(0, 200)) - 100;
        b = 32'(-$signed(a) * (r1 + r2)) << 8;
        c = 32'($signed(a) * r1 * r2);
        a = a << 8;
        c = c << 8;
        c = c + 32'($signed($urandom_range(0, 6)) - 3);
      end else if (k < 7) begin
        a = 32'd0;
        b = rand_coef();
        c = $urandom_range(1) ? 32'($urandom_range(0, 20)) : rand_coef();
        if ($urandom_range(1)) c = -c;
      end else begin
        a = rand_coef();
        b = rand_coef();
        c = rand_coef();
      end
      send_coefs(a, b, c, idle_pct);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_write(ADDR_UNUSED, 32'hffff_ffff);
    apb_write(ADDR_ZERO_TOL, 32'd6);

    // directed: degenerate, linear, tolerance edge, saturation, extremes
    send_coefs(0, 0, 5, 0);
    send_coefs(0, 0, S_MIN, 0);
    send_coefs(0, ONE, 6, 0);
    send_coefs(0, ONE, 7, 0);
    send_coefs(0, -ONE, -7, 0);
    send_coefs(0, ONE, -6, 0);
    send_coefs(0, 1, S_MAX, 0);
    send_coefs(0, -1, S_MAX, 0);
    send_coefs(0, S_MIN, S_MAX, 0);
    send_coefs(0, S_MIN, S_MIN, 0);
    send_coefs(ONE, 0, -(4 * ONE), 0);
    send_coefs(ONE, 0, 4 * ONE, 0);
    send_coefs(ONE, -2 * ONE, ONE, 0);
    send_coefs(-ONE, 2 * ONE, 3 * ONE, 0);
    send_coefs(S_MIN, S_MIN, S_MIN, 0);
    send_coefs(S_MAX, S_MAX, S_MAX, 0);
    send_coefs(S_MIN, S_MAX, S_MIN, 0);
    send_coefs(1, S_MAX, 0, 0);
    send_coefs(1, S_MIN, S_MAX, 0);
    send_coefs(S_MAX, 0, 0, 0);
    send_coefs(1, 0, S_MIN, 0);
    send_coefs(-1, 0, S_MAX, 0);

    drain_and_set(16'd0);
    send_random(130, 15);
    drain_and_set(16'hffff);
    send_coefs(0, ONE, 16'hffff, 0);
    send_coefs(0, ONE, 32'h0001_0000, 0);
    send_random(130, 84);
    drain_and_set(16'($urandom()));
    send_random(120, 0);
    drain_and_set(16'd6);
    send_random(20, 50);

    start_i <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
    $display("Sent %0d coefficient triples over four tolerance settings (0, 6, max, random),",
             sent_count);
    $display("covering degenerate, linear, no-root, saturating and random equations.");
    if (mismatch_count == 0 && open_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/qmrr_pkg.sv
rtl/quadratic_max_real_root_unit.sv
sim/qmrr_checker.sv
sim/tb_top.sv
